// File: design/satu_pkg.sv
// satu_pkg: shared types and constants for the sorted array table unit.
// Used by every file in the design folder; depends on nothing.

package satu_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int VALUE_W          = 32;
   localparam int INDEX_W          = 8;
   localparam int CFG_W            = 9;
   localparam int COUNT_OUT_W      = 9;
   localparam int GROUP_SIZE       = 16;

   localparam logic [CFG_W-1:0] CAP_RESET = 9'd256;

   // opcodes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_GET    = 2'd2;
   localparam logic [1:0] OP_FIND   = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
   } req_item_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [INDEX_W-1:0]     position;
      logic [VALUE_W-1:0]     read_value;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_item_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic               do_insert;
      logic               do_remove;
      logic               do_find;
      logic               do_get;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
   } cell_ctrl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic [VALUE_W-1:0] entry;
      logic               occ;
      logic               greater;
      logic               eq;
   } cell_link_type;

endpackage

// File: design/satu_cell.sv
// satu_cell: one slot of the sorted table; compares against the broadcast
// value and shifts entries up (insert) or down (remove). Uses satu_pkg.

module satu_cell #(
   parameter int IDX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  satu_pkg::cell_ctrl_type ctrl,
   input  satu_pkg::cell_link_type prev_link,
   input  satu_pkg::cell_link_type next_link,
   output satu_pkg::cell_link_type link,
   output logic                    hit,
   output logic [satu_pkg::VALUE_W-1:0] get_data
);

   logic [satu_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic                         occ_ff, occ_in;
   logic                         greater, eq, prev_le, ins_here, first_eq;
   logic                         at_idx, at_or_above;

   assign greater     = occ_ff && (ctrl.value < entry_ff);
   assign eq          = occ_ff && (entry_ff == ctrl.value);
   assign prev_le     = prev_link.occ && !prev_link.greater;
   // new value lands where the left neighbor is occupied and not greater and this one is greater or empty
   assign ins_here    = prev_le && (greater || !occ_ff);
   // equal values sit together, so the first match is where the run starts
   assign first_eq    = eq && !prev_link.eq;
   assign at_idx      = (IDX == int'(ctrl.index));
   assign at_or_above = (IDX >= int'(ctrl.index));

   assign link.entry   = entry_ff;
   assign link.occ     = occ_ff;
   assign link.greater = greater;
   assign link.eq      = eq;

   assign hit      = (ctrl.do_insert && ins_here) || (ctrl.do_find && first_eq);
   assign get_data = (ctrl.do_get && at_idx) ? entry_ff : '0;

   always_comb begin
      entry_in = entry_ff;
      occ_in   = occ_ff;
      if (ctrl.do_insert) begin
         if (prev_link.greater) begin
            entry_in = prev_link.entry;
         end else if (ins_here) begin
            entry_in = ctrl.value;
         end
         occ_in = prev_link.occ;
      end else if (ctrl.do_remove && at_or_above) begin
         entry_in = next_link.entry;
         occ_in   = next_link.occ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         occ_ff   <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         occ_ff   <= occ_in;
      end
   end

endmodule

// File: design/satu_collect.sv
// satu_collect: two-level OR tree that gathers the one-hot cell hits into a
// position and the selected read data. Uses satu_pkg.

module satu_collect #(
   parameter int NUM_CELLS = satu_pkg::CAPACITY_DEFAULT
) (
   input  logic                         clock,
   input  logic                         capture,
   input  logic [NUM_CELLS-1:0]         hit,
   input  logic [satu_pkg::VALUE_W-1:0] get_data [NUM_CELLS],
   output logic                         any_hit,
   output logic [satu_pkg::INDEX_W-1:0] pos,
   output logic [satu_pkg::VALUE_W-1:0] rd
);

   localparam int GS   = satu_pkg::GROUP_SIZE;
   localparam int NG   = (NUM_CELLS + GS - 1) / GS;
   localparam int NPAD = NG * GS;

   logic [NPAD-1:0]              hit_pad;
   logic [satu_pkg::VALUE_W-1:0] data_pad [NPAD];

   logic                         grp_any_in [NG];
   logic [satu_pkg::INDEX_W-1:0] grp_pos_in [NG];
   logic [satu_pkg::VALUE_W-1:0] grp_rd_in  [NG];
   logic                         grp_any_ff [NG];
   logic [satu_pkg::INDEX_W-1:0] grp_pos_ff [NG];
   logic [satu_pkg::VALUE_W-1:0] grp_rd_ff  [NG];

   assign hit_pad = NPAD'(hit);

   for (genvar c = 0; c < NPAD; c++) begin : g_pad
      if (c < NUM_CELLS) begin : g_real
         assign data_pad[c] = get_data[c];
      end else begin : g_zero
         assign data_pad[c] = '0;
      end
   end

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_any_in[g] = 1'b0;
         grp_pos_in[g] = '0;
         grp_rd_in[g]  = '0;
         for (int k = 0; k < GS; k++) begin
            grp_any_in[g] = grp_any_in[g] | hit_pad[g*GS+k];
            grp_pos_in[g] = grp_pos_in[g]
                          | (hit_pad[g*GS+k] ? satu_pkg::INDEX_W'(g*GS+k) : '0);
            grp_rd_in[g]  = grp_rd_in[g] | data_pad[g*GS+k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         for (int g = 0; g < NG; g++) begin
            grp_any_ff[g] <= grp_any_in[g];
            grp_pos_ff[g] <= grp_pos_in[g];
            grp_rd_ff[g]  <= grp_rd_in[g];
         end
      end
   end

   always_comb begin
      any_hit = 1'b0;
      pos     = '0;
      rd      = '0;
      for (int g = 0; g < NG; g++) begin
         any_hit = any_hit | grp_any_ff[g];
         pos     = pos | grp_pos_ff[g];
         rd      = rd | grp_rd_ff[g];
      end
   end

endmodule

// File: design/sorted_array_table_unit.sv
// Sorted array table: keeps up to CAPACITY 32-bit unsigned values in
// ascending order in a row of cells, one slot per cell. Insert (after equal
// values), remove at index, get at index and find first match each update or
// search every cell at once in the transfer cycle. The result is gathered
// through a two-level registered OR tree over the cells (group register,
// then output register) and is then offered until it transfers. One
// operation is in flight at a time, so the table takes a new request only
// once the previous result has transferred. The capacity register may be
// written when idle.
// Depends on satu_pkg, satu_cell and satu_collect.

module sorted_array_table_unit #(
   parameter int CAPACITY = satu_pkg::CAPACITY_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  satu_pkg::req_item_type       req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output satu_pkg::rsp_item_type       rsp_data,
   input  logic                         csr_write_enable,
   input  logic [satu_pkg::CFG_W-1:0]   csr_write_data
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > satu_pkg::CFG_W) ? CW : satu_pkg::CFG_W;

   typedef enum logic [2:0] {
      FSM_IDLE   = 3'b001,
      FSM_REDUCE = 3'b010,
      FSM_RESP   = 3'b100
   } fsm_type;

   fsm_type                        fsm_ff, fsm_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [satu_pkg::CFG_W-1:0]     cap_ff;
   logic [1:0]                     op_ff;
   logic [1:0]                     status_ff, status_in;
   logic [satu_pkg::INDEX_W-1:0]   pos_ff;
   satu_pkg::rsp_item_type         rsp_ff, rsp_in;

   logic                           req_xfer, rsp_xfer;
   logic                           is_full, bad_remove, bad_get;
   satu_pkg::cell_ctrl_type        ctrl;
   satu_pkg::cell_link_type        links [CAPACITY];
   satu_pkg::cell_link_type        edge_first, edge_last;
   logic [CAPACITY-1:0]            hits;
   logic [satu_pkg::VALUE_W-1:0]   get_data [CAPACITY];
   logic                           any_hit;
   logic [satu_pkg::INDEX_W-1:0]   col_pos;
   logic [satu_pkg::VALUE_W-1:0]   col_rd;

   assign req_stall = (fsm_ff != FSM_IDLE);
   assign rsp_valid = (fsm_ff == FSM_RESP);
   assign rsp_data  = rsp_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   assign is_full    = (count_ff >= CW'(CAPACITY)) || (CMPW'(count_ff) >= CMPW'(cap_ff));
   assign bad_remove = CMPW'(req_data.index) >= CMPW'(count_ff);
   assign bad_get    = CMPW'(req_data.index) >= CMPW'(CAPACITY);

   always_comb begin
      ctrl.do_insert = req_xfer && (req_data.opcode == satu_pkg::OP_INSERT) && !is_full;
      ctrl.do_remove = req_xfer && (req_data.opcode == satu_pkg::OP_REMOVE) && !bad_remove;
      ctrl.do_find   = req_xfer && (req_data.opcode == satu_pkg::OP_FIND);
      ctrl.do_get    = req_xfer && (req_data.opcode == satu_pkg::OP_GET) && !bad_get;
      ctrl.value     = req_data.value;
      ctrl.index     = req_data.index;
   end

   // left of cell 0 acts as an occupied slot that is never greater
   assign edge_first = '{entry: '0, occ: 1'b1, greater: 1'b0, eq: 1'b0};
   assign edge_last  = '{entry: '0, occ: 1'b0, greater: 1'b0, eq: 1'b0};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      satu_pkg::cell_link_type prev_l, next_l;
      if (i == 0) begin : g_first
         assign prev_l = edge_first;
      end else begin : g_mid_p
         assign prev_l = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_l = edge_last;
      end else begin : g_mid_n
         assign next_l = links[i+1];
      end
      satu_cell #(.IDX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .prev_link (prev_l),
         .next_link (next_l),
         .link      (links[i]),
         .hit       (hits[i]),
         .get_data  (get_data[i])
      );
   end

   satu_collect #(.NUM_CELLS(CAPACITY)) u_collect (
      .clock    (clock),
      .capture  (req_xfer),
      .hit      (hits),
      .get_data (get_data),
      .any_hit  (any_hit),
      .pos      (col_pos),
      .rd       (col_rd)
   );

   always_comb begin
      status_in = satu_pkg::STATUS_OK;
      count_in  = count_ff;
      case (req_data.opcode)
         satu_pkg::OP_INSERT: begin
            if (is_full) status_in = satu_pkg::STATUS_FULL;
            else         count_in  = count_ff + 1'b1;
         end
         satu_pkg::OP_REMOVE: begin
            if (bad_remove) status_in = satu_pkg::STATUS_BAD_INDEX;
            else            count_in  = count_ff - 1'b1;
         end
         satu_pkg::OP_GET: begin
            if (bad_get) status_in = satu_pkg::STATUS_BAD_INDEX;
         end
         default: status_in = satu_pkg::STATUS_OK;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      rsp_in.entry_count = satu_pkg::COUNT_OUT_W'(count_ff);
      rsp_in.read_value  = col_rd;
      if (op_ff == satu_pkg::OP_FIND) begin
         rsp_in.status   = any_hit ? satu_pkg::STATUS_OK : satu_pkg::STATUS_NOT_FOUND;
         rsp_in.position = col_pos;
      end else if (op_ff == satu_pkg::OP_INSERT) begin
         rsp_in.status   = status_ff;
         rsp_in.position = col_pos;
      end else begin
         rsp_in.status   = status_ff;
         rsp_in.position = (status_ff == satu_pkg::STATUS_OK) ? pos_ff : '0;
      end
   end

   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         FSM_IDLE:   if (req_xfer) fsm_in = FSM_REDUCE;
         FSM_REDUCE: fsm_in = FSM_RESP;
         FSM_RESP:   if (rsp_xfer) fsm_in = FSM_IDLE;
         default:    fsm_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff   <= FSM_IDLE;
         count_ff <= '0;
         cap_ff   <= satu_pkg::CAP_RESET;
      end else begin
         fsm_ff <= fsm_in;
         if (req_xfer) count_ff <= count_in;
         if (csr_write_enable) cap_ff <= csr_write_data;
      end
   end

   // payload: captured per request transfer or in FSM_REDUCE, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff     <= req_data.opcode;
         status_ff <= status_in;
         pos_ff    <= req_data.index;
      end
      if (fsm_ff == FSM_REDUCE) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: design/satu_checker.sv
// satu_checker: port-level assertions for sorted_array_table_unit, bound to
// the top level below. Uses satu_pkg.

module satu_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input satu_pkg::rsp_item_type rsp_data
);

   // held result does not move while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one operation in flight: a request transfer closes the input side
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("input open or result shown right after request transfer");

   // every request transfer is followed by a result
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("result missing two cycles after request transfer");

   // after the result transfers the table is ready again
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !req_stall && !rsp_valid)
      else $error("input not reopened after result transfer");

endmodule

bind sorted_array_table_unit satu_checker u_satu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
